// ----- hdl/arc_pkg.sv -----
// Shared types and constants for the address resolution cache.
`default_nettype none

package arc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int SLOT_W      = 4;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} arc_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic load;
	} arc_cmd_t;

	typedef struct packed {
		logic s1_vld;
		logic match;
		logic last;
	} arc_status_t;

endpackage

`default_nettype wire

// ----- hdl/arc_req_if.sv -----
// Request channel: lookup or insert item with valid/ready handshake.
`default_nettype none

interface arc_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [arc_pkg::IP_W-1:0]     ip_address;
	logic [arc_pkg::MAC_W-1:0]    new_mac;

	modport source (output valid, req_type, ip_address, new_mac, input ready);
	modport sink   (input valid, req_type, ip_address, new_mac, output ready);
endinterface

`default_nettype wire

// ----- hdl/arc_rsp_if.sv -----
// Response channel: result item with valid/ready handshake.
`default_nettype none

interface arc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [arc_pkg::MAC_W-1:0]    found_mac;
	logic [arc_pkg::SLOT_W-1:0]   slot_index;
	logic                         evicted;

	modport source (output valid, hit, found_mac, slot_index, evicted, input ready);
	modport sink   (input valid, hit, found_mac, slot_index, evicted, output ready);
endinterface

`default_nettype wire

// ----- hdl/arc_ctrl.sv -----
// Controller state machine: sequences the table scan and the result hand-off.
`default_nettype none

module arc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire arc_pkg::arc_status_t status,
	output arc_pkg::arc_cmd_t         cmd
);

	arc_pkg::arc_state_t state_q, state_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			arc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = arc_pkg::ST_SCAN;
			end
			arc_pkg::ST_SCAN: begin
				if (status.s1_vld && (status.match || status.last)) state_nxt = arc_pkg::ST_DONE;
			end
			arc_pkg::ST_DONE: begin
				if (out_free) state_nxt = arc_pkg::ST_IDLE;
			end
			default: state_nxt = arc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			arc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			arc_pkg::ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.commit = status.s1_vld && (status.match || status.last);
			end
			arc_pkg::ST_DONE: begin
				cmd.load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/arc_dp.sv -----
// Datapath: entry memories, valid bits, scan counter, compare stage and result registers.
`default_nettype none

module arc_dp #(
	parameter int ENTRIES = arc_pkg::ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire arc_pkg::arc_cmd_t           cmd,
	output arc_pkg::arc_status_t             status,
	input  wire logic                        req_type,
	input  wire logic [arc_pkg::IP_W-1:0]    ip_address,
	input  wire logic [arc_pkg::MAC_W-1:0]   new_mac,
	output logic                             hit,
	output logic [arc_pkg::MAC_W-1:0]        found_mac,
	output logic [arc_pkg::SLOT_W-1:0]       slot_index,
	output logic                             evicted
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int XW = (IW > arc_pkg::SLOT_W) ? IW : arc_pkg::SLOT_W;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic [arc_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
	logic [arc_pkg::MAC_W-1:0] mac_mem [ENTRIES];
	logic [ENTRIES-1:0]        valid_q;

	// Request held for the whole scan
	logic                      type_q;
	logic [arc_pkg::IP_W-1:0]  ip_q;
	logic [arc_pkg::MAC_W-1:0] mac_q;

	logic [IW-1:0]             rd_idx_q;
	logic                      s1_vld_q;
	logic [IW-1:0]             idx_s1;
	logic                      vld_s1;
	logic [arc_pkg::IP_W-1:0]  ip_s1;
	logic [arc_pkg::MAC_W-1:0] mac_s1;

	logic                      res_hit_q;
	logic [arc_pkg::MAC_W-1:0] res_mac_q;
	logic [XW-1:0]             res_slot_q;
	logic                      res_ev_q;

	logic                      ip_eq;
	logic                      match;
	logic                      is_insert;
	logic [IW-1:0]             wr_idx;

	assign is_insert = (type_q == arc_pkg::REQ_INSERT);
	assign ip_eq     = (ip_s1 == ip_q);
	// An insert may take a free slot; a lookup needs a live entry
	assign match     = is_insert ? (!vld_s1 || ip_eq) : (vld_s1 && ip_eq);
	assign wr_idx    = match ? idx_s1 : '0;

	assign status.s1_vld = s1_vld_q;
	assign status.match  = match;
	assign status.last   = (idx_s1 == LAST);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			type_q <= req_type;
			ip_q   <= ip_address;
			mac_q  <= new_mac;
		end
		if (cmd.scan) begin
			ip_s1  <= ip_mem[rd_idx_q];
			mac_s1 <= mac_mem[rd_idx_q];
			vld_s1 <= valid_q[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
		if (cmd.commit && is_insert) begin
			ip_mem[wr_idx]  <= ip_q;
			mac_mem[wr_idx] <= mac_q;
		end
		if (cmd.commit) begin
			res_hit_q  <= match && (is_insert ? vld_s1 : 1'b1);
			res_mac_q  <= (!is_insert && match) ? mac_s1 : '0;
			res_slot_q <= XW'(wr_idx);
			res_ev_q   <= is_insert && !match;
		end
		if (cmd.load) begin
			hit        <= res_hit_q;
			found_mac  <= res_mac_q;
			slot_index <= res_slot_q[arc_pkg::SLOT_W-1:0];
			evicted    <= res_ev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_idx_q <= '0;
			s1_vld_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_idx_q <= '0;
				s1_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				s1_vld_q <= 1'b1;
				if (rd_idx_q != LAST) rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.commit && is_insert) valid_q[wr_idx] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/address_resolution_cache.sv -----
// Scan: entries are compared in slot order from slot 0 until a match or the last slot,
// one entry compared per cycle behind the memory read register.
// Flow: one item at a time; the next item is accepted once the result has moved
// into the output register.
// Reset: arst_n clears all valid bits, the controller and the output valid at once;
// no clearing pass is needed.
`default_nettype none

module address_resolution_cache #(
	parameter int ENTRIES = arc_pkg::ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	arc_req_if.sink  req,
	arc_rsp_if.source rsp
);

	arc_pkg::arc_cmd_t    cmd;
	arc_pkg::arc_status_t status;

	arc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	arc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.req_type   (req.req_type),
		.ip_address (req.ip_address),
		.new_mac    (req.new_mac),
		.hit        (rsp.hit),
		.found_mac  (rsp.found_mac),
		.slot_index (rsp.slot_index),
		.evicted    (rsp.evicted)
	);

	a_evict_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> (rsp.slot_index == '0) && !rsp.hit)
		else $error("eviction must target slot 0 without a hit");

	a_miss_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> (rsp.found_mac == '0))
		else $error("found_mac must be zero without a lookup hit");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("a second item accepted while one is in flight");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.commit, cmd.load}))
		else $error("controller issued overlapping commands");

endmodule

`default_nettype wire
